FILE: src/fqsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fqsr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int HANDLE_W  = 16;
  localparam int ID_W      = 15;
  localparam int THREAD_W  = 16;
  localparam int KEY_W     = 16;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    logic [THREAD_W-1:0] thread;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic push_wr;
    logic res_full;
    logic res_miss;
    logic scan_clr;
    logic rd_scan;
    logic scan_inc;
    logic hit_lookup;
    logic hit_remove;
    logic rd_shift;
    logic wr_shift;
    logic dec_count;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op_in;
    logic key_neg;
    op_t  op_q;
    logic empty;
    logic full;
    logic match;
    logic last;
    logic more;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/fqsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fqsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/fqsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fqsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fqsr_pkg::dp_stat_t stat,
  output fqsr_pkg::dp_cmd_t      cmd
);

  import fqsr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (stat.op_in)
            OP_PUSH:   state_next = S_FINISH;
            OP_POP:    state_next = stat.empty ? S_FINISH : S_SCAN_RD;
            OP_LOOKUP: state_next = (stat.empty || stat.key_neg) ? S_FINISH : S_SCAN_RD;
            OP_DELETE: state_next = stat.empty ? S_FINISH : S_SCAN_RD;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.match) begin
          state_next = (stat.op_q == OP_LOOKUP) ? S_FINISH : S_SHIFT;
        end else if (stat.last) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT:    state_next = stat.more ? S_SHIFT_WR : S_FINISH;
      S_SHIFT_WR: state_next = S_SHIFT;
      S_FINISH:   state_next = stat.out_busy ? S_FINISH : S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.op_in)
            OP_PUSH: begin
              cmd.res_full = stat.full;
              cmd.push_wr  = !stat.full;
            end
            OP_LOOKUP: begin
              cmd.res_miss = stat.empty || stat.key_neg;
              cmd.scan_clr = !(stat.empty || stat.key_neg);
            end
            default: begin
              cmd.res_miss = stat.empty;
              cmd.scan_clr = !stat.empty;
            end
          endcase
        end
      end
      S_SCAN_RD: cmd.rd_scan = 1'b1;
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.hit_lookup = (stat.op_q == OP_LOOKUP);
          cmd.hit_remove = (stat.op_q != OP_LOOKUP);
        end else if (stat.last) begin
          cmd.res_miss = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.rd_shift  = stat.more;
        cmd.dec_count = !stat.more;
      end
      S_SHIFT_WR: cmd.wr_shift = 1'b1;
      S_FINISH:   cmd.load_out = !stat.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/fqsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module fqsr_dp #(
  parameter int DEPTH = fqsr_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire fqsr_pkg::dp_cmd_t                  cmd,
  output fqsr_pkg::dp_stat_t                      stat,
  input  wire logic [1:0]                         op,
  input  wire logic [fqsr_pkg::HANDLE_W-1:0]      entry_handle,
  input  wire logic [fqsr_pkg::ID_W-1:0]          entry_id,
  input  wire logic [fqsr_pkg::THREAD_W-1:0]      entry_thread,
  input  wire logic signed [fqsr_pkg::KEY_W-1:0]  key_id,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              status,
  output logic [fqsr_pkg::HANDLE_W-1:0]           out_handle,
  output logic [fqsr_pkg::THREAD_W-1:0]           out_thread,
  output logic [fqsr_pkg::COUNT_W-1:0]            count
);

  import fqsr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    entry_count;
  logic [IDX_W-1:0]    idx;
  op_t                 op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [ID_W-1:0]     key_q;
  status_t             w_status;
  logic [HANDLE_W-1:0] w_handle;
  logic [THREAD_W-1:0] w_thread;
  logic [COUNT_W-1:0]  cnt_out;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  entry_t              push_entry;
  logic [CNT_W-1:0]    idx_plus;

  assign push_entry = '{handle: entry_handle, id: entry_id, thread: entry_thread};
  assign idx_plus   = CNT_W'(idx) + CNT_W'(1);

  assign ram_we    = cmd.push_wr | cmd.wr_shift;
  assign ram_waddr = cmd.push_wr ? entry_count[IDX_W-1:0] : idx;
  assign ram_wdata = cmd.push_wr ? push_entry : ram_rdata;
  assign ram_raddr = cmd.rd_shift ? (idx + IDX_W'(1)) : idx;

  fqsr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.op_in    = op_t'(op);
    stat.key_neg  = key_id[KEY_W-1];
    stat.op_q     = op_q;
    stat.empty    = (entry_count == '0);
    stat.full     = (entry_count == CNT_W'(DEPTH));
    case (op_q)
      OP_POP:    stat.match = 1'b1;
      OP_LOOKUP: stat.match = (ram_rdata.id == key_q);
      OP_DELETE: stat.match = (ram_rdata.handle == handle_q);
      default:   stat.match = 1'b0;
    endcase
    stat.last     = (idx_plus == entry_count);
    stat.more     = (idx_plus < entry_count);
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.push_wr) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (cmd.dec_count) begin
      entry_count <= entry_count - CNT_W'(1);
    end
  end

  // working result and scan index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op_t'(op);
      handle_q <= entry_handle;
      key_q    <= key_id[ID_W-1:0];
      w_handle <= '0;
      w_thread <= '0;
      if (cmd.res_full) begin
        w_status <= ST_FULL;
      end else if (cmd.res_miss) begin
        w_status <= ST_MISS;
      end else begin
        w_status <= ST_OK;
      end
    end else if (cmd.res_miss) begin
      w_status <= ST_MISS;
    end else if (cmd.hit_lookup) begin
      w_thread <= ram_rdata.thread;
    end else if (cmd.hit_remove && op_q == OP_POP) begin
      w_handle <= ram_rdata.handle;
    end
    if (cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.scan_inc || cmd.wr_shift) begin
      idx <= idx + IDX_W'(1);
    end
  end

  generate
    if (CNT_W >= COUNT_W) begin : g_cnt_trunc
      assign cnt_out = entry_count[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_out = {{(COUNT_W - CNT_W){1'b0}}, entry_count};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= w_status;
      out_handle <= w_handle;
      out_thread <= w_thread;
      count      <= cnt_out;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_wr |-> (entry_count < CNT_W'(DEPTH)))
    else $error("push write into full queue");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_scan |-> (CNT_W'(idx) < entry_count))
    else $error("scan read beyond tail");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("result overwrites a pending transaction");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_count |-> (entry_count != '0))
    else $error("removal from empty queue");
`endif

endmodule
`default_nettype wire

FILE: src/fifo_queue_search_remove_top.sv
// From accept to out_valid: a push, a negative-key lookup or any op on an empty queue
// goes straight to the finish state; a lookup, pop or delete scans slots in order (a
// read then a compare state per slot) to a hit or the tail; a pop or delete hit then
// shifts later entries down. One operation at a time: the next is accepted the cycle
// after the result is registered; a stalled result holds the next one in finish state.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module fifo_queue_search_remove_top #(
  parameter int DEPTH = fqsr_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         op,
  input  wire logic [fqsr_pkg::HANDLE_W-1:0]      entry_handle,
  input  wire logic [fqsr_pkg::ID_W-1:0]          entry_id,
  input  wire logic [fqsr_pkg::THREAD_W-1:0]      entry_thread,
  input  wire logic signed [fqsr_pkg::KEY_W-1:0]  key_id,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              status,
  output logic [fqsr_pkg::HANDLE_W-1:0]           out_handle,
  output logic [fqsr_pkg::THREAD_W-1:0]           out_thread,
  output logic [fqsr_pkg::COUNT_W-1:0]            count
);

  import fqsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fqsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fqsr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .entry_handle (entry_handle),
    .entry_id     (entry_id),
    .entry_thread (entry_thread),
    .key_id       (key_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_handle   (out_handle),
    .out_thread   (out_thread),
    .count        (count)
  );

endmodule
`default_nettype wire
